FILE: src/slt_pkg.sv
// shared types and constants for the shell line tokenizer
// result kinds, byte codes, result group type and queue sizing; no dependencies
package slt_pkg;

  // result kinds
  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_PIPE   = 3'd1;
  localparam logic [2:0] KIND_SEMI   = 3'd2;
  localparam logic [2:0] KIND_RIN    = 3'd3;
  localparam logic [2:0] KIND_ROUT   = 3'd4;
  localparam logic [2:0] KIND_APPEND = 3'd5;
  localparam logic [2:0] KIND_WEND   = 3'd6;
  localparam logic [2:0] KIND_DONE   = 3'd7;

  // byte codes the scanner looks at
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // group queue between scanner and output side
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // one result item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       ws;
    logic       last;
  } res_t;

  // all results caused by one input byte (at most two)
  typedef struct packed {
    res_t [1:0] slot;
    logic [1:0] cnt;
  } grp_t;

  // queue status seen by the scanner
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: src/shell_line_tokenizer.sv
// Shell command-line tokenizer. One line byte is taken per cycle whenever the
// group queue has room; each byte makes zero, one or two result items (word
// byte, operator, word end, line done), and results leave one item per cycle,
// unless out_stall holds them, from a registered output stage. The sustained
// rate is set by the output port at one result per cycle while it is not
// stalled, with a four-group queue letting the scanner run ahead while the
// output is stalled. No clearing pass after reset. A '>' waits for the next
// byte to tell redirect-out from append.
// top level; depends on slt_pkg, slt_front, slt_queue, slt_back
module shell_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_char,
  output logic       out_word_start,
  output logic       out_run_last
);

  slt_pkg::qstat_t qstat;
  slt_pkg::grp_t   f_grp, q_dout;
  slt_pkg::res_t   res;
  logic            q_push, q_pop;

  // scanner
  slt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_stall (in_stall),
    .qstat    (qstat),
    .push     (q_push),
    .grp      (f_grp)
  );

  // group queue
  slt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_grp),
    .pop   (q_pop),
    .dout  (q_dout),
    .qstat (qstat)
  );

  // result serializer
  slt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .qdata     (q_dout),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_token_kind = res.kind;
  assign out_char       = res.ch;
  assign out_word_start = res.ws;
  assign out_run_last   = res.last;

`ifndef ASSERT_OFF
  // scanner never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !qstat.full)
    else $error("group pushed into full queue");

  // serializer never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("group popped from empty queue");

  // non-byte results carry no byte and no word start
  a_clean_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind != slt_pkg::KIND_BYTE) |->
      (out_char == 8'h00 && !out_word_start))
    else $error("operator result carries byte data");
`endif

endmodule

FILE: src/slt_front.sv
// scanner: accepts line bytes, tracks scan mode and pending '>', builds result groups
// depends on slt_pkg
module slt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_ch,
  output logic            in_stall,
  input  slt_pkg::qstat_t qstat,
  output logic            push,
  output slt_pkg::grp_t   grp
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_SQ   = 2'd2;
  localparam logic [1:0] MODE_DQ   = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic       gt_r, gt_nxt;
  logic       accept;

  assign in_stall = qstat.full;
  assign accept   = in_valid & ~qstat.full;
  assign push     = accept & (grp.cnt != 2'd0);

  // classify the byte and build its result group
  always_comb begin
    logic [1:0] n;
    logic [1:0] nm1;
    logic       blank;
    logic       sep;
    grp      = '0;
    n        = 2'd0;
    nm1      = 2'd0;
    mode_nxt = mode_r;
    gt_nxt   = gt_r;
    blank    = (in_ch == slt_pkg::CH_SPACE) ||
               ((in_ch >= slt_pkg::CH_TAB) && (in_ch <= slt_pkg::CH_CR));
    sep      = blank || (in_ch == slt_pkg::CH_PIPE) || (in_ch == slt_pkg::CH_SEMI) ||
               (in_ch == slt_pkg::CH_LT) || (in_ch == slt_pkg::CH_GT);
    if (gt_r && in_ch == slt_pkg::CH_GT) begin
      // second '>' makes an append and is consumed
      gt_nxt = 1'b0;
      grp.slot[0].kind = slt_pkg::KIND_APPEND;
      n = 2'd1;
    end else begin
      if (gt_r) begin
        gt_nxt = 1'b0;
        grp.slot[0].kind = slt_pkg::KIND_ROUT;
        n = 2'd1;
      end
      if (in_ch == slt_pkg::CH_NUL) begin
        // end of line closes any open word
        if (mode_r != MODE_IDLE) begin
          grp.slot[n[0]].kind = slt_pkg::KIND_WEND;
          n = n + 2'd1;
        end
        grp.slot[n[0]].kind = slt_pkg::KIND_DONE;
        n = n + 2'd1;
        mode_nxt = MODE_IDLE;
      end else if (mode_r == MODE_SQ || mode_r == MODE_DQ) begin
        // quoted run passes every byte but NUL through
        grp.slot[n[0]].kind = slt_pkg::KIND_BYTE;
        grp.slot[n[0]].ch   = in_ch;
        n = n + 2'd1;
        if ((mode_r == MODE_SQ && in_ch == slt_pkg::CH_SQ) ||
            (mode_r == MODE_DQ && in_ch == slt_pkg::CH_DQ)) begin
          mode_nxt = MODE_WORD;
        end
      end else if (sep) begin
        // separator ends the word; pipe, semicolon and '<' give a token, '>' is held
        if (mode_r == MODE_WORD) begin
          grp.slot[n[0]].kind = slt_pkg::KIND_WEND;
          n = n + 2'd1;
        end
        mode_nxt = MODE_IDLE;
        if (in_ch == slt_pkg::CH_PIPE) begin
          grp.slot[n[0]].kind = slt_pkg::KIND_PIPE;
          n = n + 2'd1;
        end else if (in_ch == slt_pkg::CH_SEMI) begin
          grp.slot[n[0]].kind = slt_pkg::KIND_SEMI;
          n = n + 2'd1;
        end else if (in_ch == slt_pkg::CH_LT) begin
          grp.slot[n[0]].kind = slt_pkg::KIND_RIN;
          n = n + 2'd1;
        end else if (in_ch == slt_pkg::CH_GT) begin
          gt_nxt = 1'b1;
        end
      end else begin
        // plain word byte, quotes open a quoted run
        grp.slot[n[0]].kind = slt_pkg::KIND_BYTE;
        grp.slot[n[0]].ch   = in_ch;
        grp.slot[n[0]].ws   = (mode_r == MODE_IDLE);
        n = n + 2'd1;
        if (in_ch == slt_pkg::CH_SQ) begin
          mode_nxt = MODE_SQ;
        end else if (in_ch == slt_pkg::CH_DQ) begin
          mode_nxt = MODE_DQ;
        end else begin
          mode_nxt = MODE_WORD;
        end
      end
    end
    // mark the final result of this byte
    if (n != 2'd0) begin
      nm1 = n - 2'd1;
      grp.slot[nm1[0]].last = 1'b1;
    end
    grp.cnt = n;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      gt_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      gt_r   <= gt_nxt;
    end
  end

endmodule

FILE: src/slt_queue.sv
// short queue of result groups between scanner and output side
// depends on slt_pkg
module slt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  slt_pkg::grp_t   din,
  input  logic            pop,
  output slt_pkg::grp_t   dout,
  output slt_pkg::qstat_t qstat
);

  slt_pkg::grp_t                mem_r [slt_pkg::Q_DEPTH];
  logic [slt_pkg::Q_AW-1:0]     wptr_r, rptr_r;
  logic [slt_pkg::Q_CW-1:0]     cnt_r;
  logic                         do_push, do_pop;

  assign qstat.full  = (cnt_r == slt_pkg::Q_CW'(slt_pkg::Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign dout        = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/slt_back.sv
// output side: holds one result group, hands out one item a cycle unless stalled
// depends on slt_pkg
module slt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  slt_pkg::qstat_t qstat,
  input  slt_pkg::grp_t   qdata,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output slt_pkg::res_t   res
);

  slt_pkg::grp_t cur_r;
  logic          valid_r;
  logic          sel_r;
  logic          taken;
  logic          last_slot;

  assign out_valid = valid_r;
  assign res       = cur_r.slot[sel_r];
  assign taken     = valid_r & ~out_stall;
  assign last_slot = sel_r | (cur_r.cnt == 2'd1);
  assign pop       = ~qstat.empty & (~valid_r | (taken & last_slot));

  // group payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= qdata;
    end
  end

  // slot select and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
      sel_r   <= 1'b0;
    end else if (taken && !last_slot) begin
      sel_r <= 1'b1;
    end else if (taken) begin
      valid_r <= 1'b0;
    end
  end

endmodule

FILE: dv/shell_line_tokenizer_tb.sv
// testbench for shell_line_tokenizer: directed and random command lines with
// an in-bench scanner model and an ordered result check; depends on slt_pkg
module shell_line_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_WORD   = 2'd1,
    SCAN_SQUOTE = 2'd2,
    SCAN_DQUOTE = 2'd3
  } scan_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_token_kind;
  logic [7:0] out_char;
  logic       out_word_start;
  logic       out_run_last;

  // scanner model state and tokens still owed by the block
  scan_t          scan_st;
  logic           gt_wait;
  slt_pkg::res_t  token_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_cnt;
  int bytes_sent;
  int lines_sent;
  int tokens_checked;
  int cycle_cnt;

  shell_line_tokenizer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char       (out_char),
    .out_word_start (out_word_start),
    .out_run_last   (out_run_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens still owed",
               cycle_cnt, token_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic void push_token(input logic [2:0] kind, input logic [7:0] ch,
                                     input logic ws);
    slt_pkg::res_t tok;
    tok.kind = kind;
    tok.ch   = ch;
    tok.ws   = ws;
    tok.last = 1'b0;
    token_q.push_back(tok);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == slt_pkg::CH_SPACE) || (b >= slt_pkg::CH_TAB && b <= slt_pkg::CH_CR);
  endfunction

  // expected tokens for one accepted line byte
  function automatic void tokenize_byte(input logic [7:0] b);
    int made;
    made = 0;
    // a held '>' is settled by this byte
    if (gt_wait) begin
      gt_wait = 1'b0;
      if (b == slt_pkg::CH_GT) begin
        push_token(slt_pkg::KIND_APPEND, 8'h00, 1'b0);
        token_q[token_q.size() - 1].last = 1'b1;
        return;
      end
      push_token(slt_pkg::KIND_ROUT, 8'h00, 1'b0);
      made++;
    end
    if (b == slt_pkg::CH_NUL) begin
      // end of line closes any open word, quoted or not
      if (scan_st != SCAN_IDLE) begin
        push_token(slt_pkg::KIND_WEND, 8'h00, 1'b0);
        made++;
      end
      push_token(slt_pkg::KIND_DONE, 8'h00, 1'b0);
      made++;
      scan_st = SCAN_IDLE;
    end else if (scan_st == SCAN_SQUOTE || scan_st == SCAN_DQUOTE) begin
      push_token(slt_pkg::KIND_BYTE, b, 1'b0);
      made++;
      if ((scan_st == SCAN_SQUOTE && b == slt_pkg::CH_SQ) ||
          (scan_st == SCAN_DQUOTE && b == slt_pkg::CH_DQ))
        scan_st = SCAN_WORD;
    end else if (is_blank(b) || b == slt_pkg::CH_PIPE || b == slt_pkg::CH_SEMI ||
                 b == slt_pkg::CH_LT || b == slt_pkg::CH_GT) begin
      if (scan_st == SCAN_WORD) begin
        push_token(slt_pkg::KIND_WEND, 8'h00, 1'b0);
        made++;
      end
      scan_st = SCAN_IDLE;
      case (b)
        slt_pkg::CH_PIPE: begin
          push_token(slt_pkg::KIND_PIPE, 8'h00, 1'b0);
          made++;
        end
        slt_pkg::CH_SEMI: begin
          push_token(slt_pkg::KIND_SEMI, 8'h00, 1'b0);
          made++;
        end
        slt_pkg::CH_LT: begin
          push_token(slt_pkg::KIND_RIN, 8'h00, 1'b0);
          made++;
        end
        slt_pkg::CH_GT: gt_wait = 1'b1;
        default: ;
      endcase
    end else begin
      push_token(slt_pkg::KIND_BYTE, b, scan_st == SCAN_IDLE);
      made++;
      if (b == slt_pkg::CH_SQ)
        scan_st = SCAN_SQUOTE;
      else if (b == slt_pkg::CH_DQ)
        scan_st = SCAN_DQUOTE;
      else
        scan_st = SCAN_WORD;
    end
    if (made > 0)
      token_q[token_q.size() - 1].last = 1'b1;
  endfunction

  // result check against the oldest owed token
  always @(posedge clk) begin
    slt_pkg::res_t exp_tok;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected item: kind %0d char %02h start %0d last %0d",
                   out_token_kind, out_char, out_word_start, out_run_last);
      end else begin
        exp_tok = token_q.pop_front();
        tokens_checked++;
        if (out_token_kind !== exp_tok.kind || out_char !== exp_tok.ch ||
            out_word_start !== exp_tok.ws || out_run_last !== exp_tok.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"item %0d: expected kind %0d char %02h start %0d last %0d,",
                      " got kind %0d char %02h start %0d last %0d"},
                     tokens_checked, exp_tok.kind, exp_tok.ch, exp_tok.ws, exp_tok.last,
                     out_token_kind, out_char, out_word_start, out_run_last);
        end
      end
    end
  end

  // send one line byte, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    tokenize_byte(b);
    bytes_sent++;
    if (b == slt_pkg::CH_NUL)
      lines_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // stop sending until every owed token has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0)
      @(posedge clk);
  endtask

  // a word, word end at the pipe, pipe, semicolon, redirect in, line done
  task automatic test_words_and_operators();
    send_byte(8'h01);
    send_text("b|;<");
    send_byte(slt_pkg::CH_NUL);
  endtask

  // held '>' resolved as redirect out before a byte, or as append
  task automatic test_greater_than();
    send_text("x>y>>");
    send_byte(slt_pkg::CH_NUL);
  endtask

  // quote inside a word, operators inside quotes, unterminated quote at end of line
  task automatic test_quoting();
    send_text("a' |'c\" ");
    send_byte(slt_pkg::CH_NUL);
  endtask

  // top byte value, carriage return and tab as blanks, '>' right before end of line
  task automatic test_extremes();
    send_byte(8'hFF);
    send_byte(slt_pkg::CH_CR);
    send_byte(slt_pkg::CH_TAB);
    send_byte(slt_pkg::CH_GT);
    send_byte(slt_pkg::CH_NUL);
  endtask

  // one byte of a well-formed line, weighted toward the interesting classes
  function automatic logic [7:0] line_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 35)
      b = 8'($urandom_range(8'h61, 8'h7A));
    else if (r < 47)
      b = $urandom_range(0, 1) ? slt_pkg::CH_SPACE : 8'($urandom_range(9, 13));
    else if (r < 67) begin
      case ($urandom_range(0, 3))
        0: b = slt_pkg::CH_PIPE;
        1: b = slt_pkg::CH_SEMI;
        2: b = slt_pkg::CH_LT;
        default: b = slt_pkg::CH_GT;
      endcase
    end else if (r < 77)
      b = $urandom_range(0, 1) ? slt_pkg::CH_SQ : slt_pkg::CH_DQ;
    else
      b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  // random lines, mostly well formed, some raw noise; optional pause midway
  task automatic test_random_lines(input int n_bytes, input int pause_at);
    int  sent;
    int  len;
    bit  noisy;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_bytes) begin
      noisy = ($urandom_range(0, 9) == 0);
      len   = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (noisy) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 11) == 0) begin
            send_byte(slt_pkg::CH_GT);
            sent++;
          end
          send_byte(line_byte());
        end
        sent++;
      end
      send_byte(slt_pkg::CH_NUL);
      sent++;
      if (pause_at > 0 && !paused && sent >= pause_at) begin
        wait_results_drained();
        paused = 1'b1;
      end
    end
  endtask

  // main sequence
  initial begin
    in_valid       = 1'b0;
    in_ch          = 8'h00;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    scan_st        = SCAN_IDLE;
    gt_wait        = 1'b0;
    mismatch_cnt   = 0;
    bytes_sent     = 0;
    lines_sent     = 0;
    tokens_checked = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 29;
    recv_idle_pct  = 73;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_words_and_operators();
    test_greater_than();
    test_quoting();
    test_extremes();
    test_random_lines(40, 20);

    send_idle_pct = 73;
    recv_idle_pct = 29;
    test_random_lines(40, 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(40, 0);

    // let the output side finish
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (token_q.size() != 0) begin
      mismatch_cnt += token_q.size();
      $display("%0d tokens never came out", token_q.size());
    end

    $display("sent %0d bytes in %0d lines, checked %0d tokens over three idle mixes",
             bytes_sent, lines_sent, tokens_checked);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
